@@ rtl/hkr_pkg.sv @@
`default_nettype none

package hkr_pkg;

  // List capacity and the number of slots shown in a report
  localparam int KEY_SLOTS    = 6;
  localparam int REPORT_SLOTS = 6;
  localparam int SHOW_SLOTS   = (KEY_SLOTS < REPORT_SLOTS) ? KEY_SLOTS : REPORT_SLOTS;
  localparam int CNT_W        = $clog2(KEY_SLOTS + 1);

  // Modifier usages 0xE0..0xE7 share this upper pattern
  localparam logic [4:0] MOD_PREFIX = 5'b11100;

  // Command codes
  localparam logic [1:0] CMD_PRESS       = 2'd0;
  localparam logic [1:0] CMD_RELEASE     = 2'd1;
  localparam logic [1:0] CMD_RELEASE_ALL = 2'd2;
  localparam logic [1:0] CMD_QUERY       = 2'd3;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] keycode;
  } item_t;

  typedef struct packed {
    logic [7:0] modifier_mask;
    logic [7:0] slot_zero;
    logic [7:0] slot_one;
    logic [7:0] slot_two;
    logic [7:0] slot_three;
    logic [7:0] slot_four;
    logic [7:0] slot_five;
    logic       is_held;
    logic       report_due;
  } result_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

endpackage

`default_nettype wire

@@ rtl/hid_keyboard_report_tracker.sv @@
// An accepted item is held in the item register, and its result is registered in the update state.
// A new item is taken only after the last result is shown; busy stays high from accept to result.
// The result is shown for one cycle with done high and cannot be stalled.
// Reset (rst, synchronous) clears the modifier mask and the held-key list.
`default_nettype none

module hid_keyboard_report_tracker
  import hkr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire item_t item,
  output logic       busy,
  output logic       done,
  output result_t    result
);

  dp_cmd_t dp_cmd;

  // Sequence each item
  hkr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .dp_cmd (dp_cmd)
  );

  // Keep key state and build the report
  hkr_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .dp_cmd (dp_cmd),
    .item   (item),
    .result (result)
  );

endmodule

`default_nettype wire

@@ rtl/hkr_ctrl.sv @@
`default_nettype none

module hkr_ctrl
  import hkr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  output logic         busy,
  output logic         done,
  output dp_cmd_t      dp_cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DONE
  } state_t;

  state_t state;

  // Load the item on accept, update state in the next cycle
  always_comb begin
    dp_cmd.load = (state == ST_IDLE) && start;
    dp_cmd.exec = (state == ST_EXEC);
  end

  // Advance through load, update and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          done <= 1'b0;
          if (start) begin
            state <= ST_EXEC;
            busy  <= 1'b1;
          end
        end
        ST_EXEC: begin
          state <= ST_DONE;
          done  <= 1'b1;
        end
        ST_DONE: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
          done  <= 1'b0;
        end
        default: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
          done  <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/hkr_datapath.sv @@
`default_nettype none

module hkr_datapath
  import hkr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire dp_cmd_t dp_cmd,
  input  wire item_t   item,
  output result_t      result
);

  logic [1:0]       cmd_q;
  logic [7:0]       key_q;
  logic [7:0]       modifier_bits;
  logic [7:0]       held_keys [KEY_SLOTS];
  logic [CNT_W-1:0] held_count;

  logic [7:0]       modifier_bits_next;
  logic [7:0]       held_keys_next [KEY_SLOTS];
  logic [CNT_W-1:0] held_count_next;
  logic [7:0]       keys_up [KEY_SLOTS];
  logic [7:0]       shown [REPORT_SLOTS];
  logic [KEY_SLOTS-1:0] hit;
  logic [KEY_SLOTS-1:0] shift_mask;
  logic             found;
  logic             is_mod;
  logic [7:0]       mbit;
  logic             held;
  logic             acc;

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      cmd_q <= item.command;
      key_q <= item.keycode;
    end
  end

  // Decode the key and search the held list in parallel
  always_comb begin
    is_mod = (key_q[7:3] == MOD_PREFIX);
    mbit   = is_mod ? (8'd1 << key_q[2:0]) : 8'd0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      hit[i] = (CNT_W'(i) < held_count) && (held_keys[i] == key_q);
    end
    found = |hit;
    // Mark entries at and after the match for the shift down
    acc = 1'b0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      acc           = acc | hit[i];
      shift_mask[i] = acc;
    end
    for (int i = 0; i < KEY_SLOTS - 1; i++) begin
      keys_up[i] = held_keys[i + 1];
    end
    keys_up[KEY_SLOTS-1] = 8'd0;
  end

  // Compute the next key state for the command
  always_comb begin
    modifier_bits_next = modifier_bits;
    held_keys_next     = held_keys;
    held_count_next    = held_count;
    held               = 1'b0;
    case (cmd_q)
      CMD_PRESS: begin
        if (is_mod) begin
          modifier_bits_next = modifier_bits | mbit;
        end else if (!found && (held_count < CNT_W'(KEY_SLOTS))) begin
          for (int i = 0; i < KEY_SLOTS; i++) begin
            if (held_count == CNT_W'(i)) begin
              held_keys_next[i] = key_q;
            end
          end
          held_count_next = held_count + CNT_W'(1);
        end
      end
      CMD_RELEASE: begin
        if (is_mod) begin
          modifier_bits_next = modifier_bits & ~mbit;
        end else if (found) begin
          for (int i = 0; i < KEY_SLOTS; i++) begin
            if (shift_mask[i]) begin
              held_keys_next[i] = keys_up[i];
            end
          end
          held_count_next = held_count - CNT_W'(1);
        end
      end
      CMD_RELEASE_ALL: begin
        modifier_bits_next = 8'd0;
        for (int i = 0; i < KEY_SLOTS; i++) begin
          held_keys_next[i] = 8'd0;
        end
        held_count_next = '0;
      end
      CMD_QUERY: begin
        held = is_mod ? |(modifier_bits & mbit) : found;
      end
      default: begin
        held = 1'b0;
      end
    endcase
  end

  // Pick the slots shown in the report, zero past the capacity
  always_comb begin
    for (int i = 0; i < REPORT_SLOTS; i++) begin
      shown[i] = 8'd0;
    end
    for (int i = 0; i < SHOW_SLOTS; i++) begin
      shown[i] = held_keys_next[i];
    end
  end

  // Commit key state
  always_ff @(posedge clk) begin
    if (rst) begin
      modifier_bits <= 8'd0;
      held_count    <= '0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        held_keys[i] <= 8'd0;
      end
    end else if (dp_cmd.exec) begin
      modifier_bits <= modifier_bits_next;
      held_count    <= held_count_next;
      held_keys     <= held_keys_next;
    end
  end

  // Register the result item
  always_ff @(posedge clk) begin
    if (dp_cmd.exec) begin
      result.modifier_mask <= modifier_bits_next;
      result.slot_zero     <= shown[0];
      result.slot_one      <= shown[1];
      result.slot_two      <= shown[2];
      result.slot_three    <= shown[3];
      result.slot_four     <= shown[4];
      result.slot_five     <= shown[5];
      result.is_held       <= held;
      result.report_due    <= (cmd_q != CMD_QUERY);
    end
  end

endmodule

`default_nettype wire

@@ rtl/hkr_checker.sv @@
`default_nettype none

module hkr_checker
  import hkr_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    start,
  input wire item_t   item,
  input wire logic    busy,
  input wire logic    done,
  input wire result_t result
);

  // Each accepted item gives its result strobe after the update state
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("result not delivered two cycles after accept");

  // A result strobe lasts one cycle
  assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  // No new item is taken while a result is shown
  assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("block idle while result shown");

  // Report flag follows the command of the item
  assert property (@(posedge clk) disable iff (rst)
    done |-> (result.report_due == ($past(item.command, 2) != CMD_QUERY)))
    else $error("report_due does not match command");

  // Held answer only for queries
  assert property (@(posedge clk) disable iff (rst)
    (done && result.report_due) |-> !result.is_held)
    else $error("is_held set outside a query");

endmodule

bind hid_keyboard_report_tracker hkr_checker u_hkr_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .item   (item),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire

@@ bench/hid_keyboard_report_tracker_test.sv @@
`timescale 1ns / 1ps

module hid_keyboard_report_tracker_test;
  import hkr_pkg::*;

  localparam int RANDOM_ITEMS = 1330;
  localparam int QUIET_TAIL   = 150;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  item_t   item = '0;
  logic    busy;
  logic    done;
  result_t result;

  hid_keyboard_report_tracker DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always #5 clk = ~clk;

  // Keyboard state as the block should hold it
  logic [7:0] mod_state;
  logic [7:0] key_list [0:15];
  int         key_total;

  result_t expected_reports [$];
  int      mismatch_count = 0;

  task automatic log_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      log_mismatch($sformatf("%s got %02h want %02h", name, got, want));
  endtask

  // Apply one item to the keyboard state and build the report it returns
  function automatic result_t next_report(input item_t it);
    result_t    r;
    logic       is_mod;
    logic [7:0] mbit;
    logic       held;
    int         pos;
    is_mod = (it.keycode >= 8'hE0) && (it.keycode <= 8'hE7);
    mbit   = is_mod ? (8'd1 << it.keycode[2:0]) : 8'd0;
    held   = 1'b0;
    pos    = -1;
    for (int i = key_total - 1; i >= 0; i--)
      if (key_list[i] == it.keycode) pos = i;
    case (it.command)
      CMD_PRESS: begin
        if (is_mod) begin
          mod_state = mod_state | mbit;
        end else if (pos < 0 && key_total < KEY_SLOTS) begin
          key_list[key_total] = it.keycode;
          key_total++;
        end
      end
      CMD_RELEASE: begin
        if (is_mod) begin
          mod_state = mod_state & ~mbit;
        end else if (pos >= 0) begin
          // close the gap and zero the freed tail entry
          for (int i = pos; i < key_total - 1; i++)
            key_list[i] = key_list[i + 1];
          key_list[key_total - 1] = 8'h00;
          key_total--;
        end
      end
      CMD_RELEASE_ALL: begin
        mod_state = 8'h00;
        for (int i = 0; i < 16; i++) key_list[i] = 8'h00;
        key_total = 0;
      end
      default: begin
        held = is_mod ? |(mod_state & mbit) : (pos >= 0);
      end
    endcase
    r.modifier_mask = mod_state;
    r.slot_zero     = key_list[0];
    r.slot_one      = key_list[1];
    r.slot_two      = key_list[2];
    r.slot_three    = key_list[3];
    r.slot_four     = key_list[4];
    r.slot_five     = key_list[5];
    r.is_held       = held;
    r.report_due    = (it.command != CMD_QUERY);
    return r;
  endfunction

  // Drive one item and hold it until the block takes it
  task automatic send_key_item(input logic [1:0] cmd, input logic [7:0] code);
    item_t it;
    it.command = cmd;
    it.keycode = code;
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_reports.push_back(next_report(it));
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_for_reports();
    start <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  // Compare every report against the oldest prediction
  always @(posedge clk) begin : check_reports
    result_t want;
    if (done) begin
      if (expected_reports.size() == 0) begin
        log_mismatch("report with no item waiting");
      end else begin
        want = expected_reports.pop_front();
        check_field("modifier_mask", result.modifier_mask, want.modifier_mask);
        check_field("slot_zero", result.slot_zero, want.slot_zero);
        check_field("slot_one", result.slot_one, want.slot_one);
        check_field("slot_two", result.slot_two, want.slot_two);
        check_field("slot_three", result.slot_three, want.slot_three);
        check_field("slot_four", result.slot_four, want.slot_four);
        check_field("slot_five", result.slot_five, want.slot_five);
        check_field("is_held", 8'(result.is_held), 8'(want.is_held));
        check_field("report_due", 8'(result.report_due), 8'(want.report_due));
      end
    end
  end

  task automatic test_modifiers();
    send_key_item(CMD_PRESS, 8'hE0);
    send_key_item(CMD_PRESS, 8'hE7);
    send_key_item(CMD_QUERY, 8'hE7);
    send_key_item(CMD_QUERY, 8'hE3);
    send_key_item(CMD_RELEASE, 8'hE0);
    send_key_item(CMD_RELEASE, 8'hE7);
  endtask

  task automatic test_key_list();
    // usage zero is held like any other key
    send_key_item(CMD_PRESS, 8'h00);
    send_key_item(CMD_PRESS, 8'h04);
    send_key_item(CMD_PRESS, 8'h04);
    send_key_item(CMD_PRESS, 8'hFF);
    send_key_item(CMD_RELEASE, 8'h55);
    send_key_item(CMD_QUERY, 8'h00);
    send_key_item(CMD_RELEASE, 8'h00);
  endtask

  task automatic test_list_full();
    send_key_item(CMD_PRESS, 8'hDF);
    send_key_item(CMD_PRESS, 8'hE8);
    send_key_item(CMD_PRESS, 8'h10);
    send_key_item(CMD_PRESS, 8'h11);
    // no room left: dropped, report still due
    send_key_item(CMD_PRESS, 8'h12);
    send_key_item(CMD_QUERY, 8'h12);
    send_key_item(CMD_RELEASE, 8'h04);
  endtask

  task automatic test_release_all();
    send_key_item(CMD_PRESS, 8'hE5);
    send_key_item(CMD_RELEASE_ALL, 8'hFF);
    send_key_item(CMD_QUERY, 8'h10);
    send_key_item(CMD_QUERY, 8'hE5);
  endtask

  task automatic test_random_traffic();
    logic [7:0] key_pool [0:7];
    logic [7:0] code;
    logic [1:0] cmd;
    int         pick;
    logic       idle_on;
    idle_on = 1'b1;
    for (int i = 0; i < 8; i++) key_pool[i] = 8'($urandom_range(0, 255));
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // refresh the key pool and the idle mode now and then
      if (n % 50 == 0) begin
        key_pool[$urandom_range(0, 7)] = 8'($urandom_range(0, 255));
        key_pool[$urandom_range(0, 7)] = ($urandom_range(0, 3) == 0) ? 8'h00
                                       : 8'($urandom_range(0, 255));
        idle_on = $urandom_range(0, 2) != 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) code = key_pool[$urandom_range(0, 7)];
      else if (pick < 80) code = 8'hE0 + 8'($urandom_range(0, 7));
      else code = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 42) cmd = CMD_PRESS;
      else if (pick < 72) cmd = CMD_RELEASE;
      else if (pick < 95) cmd = CMD_QUERY;
      else cmd = CMD_RELEASE_ALL;
      send_key_item(cmd, code);
      if (n == RANDOM_ITEMS / 2)
        wait_for_reports();
      else if (idle_on && n < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 4) == 0)
        pause_sender($urandom_range(1, 13));
    end
  endtask

  initial begin
    mod_state = 8'h00;
    key_total = 0;
    for (int i = 0; i < 16; i++) key_list[i] = 8'h00;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_modifiers();
    test_key_list();
    test_list_full();
    test_release_all();
    wait_for_reports();
    test_random_traffic();
    wait_for_reports();
    repeat (5) @(posedge clk);
    if (mismatch_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ hid_keyboard_report_tracker.f @@
rtl/hkr_pkg.sv
rtl/hkr_ctrl.sv
rtl/hkr_datapath.sv
rtl/hid_keyboard_report_tracker.sv
rtl/hkr_checker.sv
bench/hid_keyboard_report_tracker_test.sv
